// File: rtl/core/trailer_tlv_guid_extract_top_macros.svh
// Assertion macros for the trailer TLV GUID extractor.
`ifndef TRAILER_TLV_GUID_EXTRACT_TOP_MACROS_SVH
`define TRAILER_TLV_GUID_EXTRACT_TOP_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define TTGE_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define TTGE_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ttge_pkg.sv
// Shared types and constants for the trailer TLV GUID extractor.
package ttge_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int LEN_SHIFT  = 5;
    localparam int GUID_BYTES = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC = 2'd0,
        CFG_END   = 2'd1,
        CFG_GUID  = 2'd2
    } cfg_idx_t;

    localparam logic [7:0] GUID_TYPE_RESET = 8'd97;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_MAGIC = 3'd1,
        PH_TL    = 3'd2,
        PH_SKIP  = 3'd3,
        PH_GUID  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [23:0] stream_id;
    } result_t;

    typedef struct packed {
        logic [31:0] magic_value;
        logic [7:0]  end_type;
        logic [7:0]  guid_type;
    } cfg_t;

endpackage

// File: rtl/core/trailer_tlv_guid_extract_top.sv
// Top level of the trailer TLV GUID extractor.
//
// Input channel (in_valid/in_ready): one packet byte per word, fed from the
// packet's final byte toward its first. first_byte marks the final byte and
// starts a new search; last_byte marks the first byte, after which nothing
// of that packet follows. The first four bytes of a packet, starting with the
// first_byte word, must match magic_value (little-endian); then type-length
// bytes are walked backward.
// Output channel (out_valid/out_ready): at most one word per packet, found plus a
// 24-bit stream_id, or found low with stream_id zero.
// Result path: the input register holds the word that decides the result,
// then the parser loads the result into the register that drives out_valid.
// Throughput: one byte per cycle while no result waits on a busy slot; the
// parser's state update and the one-entry result register set that rate.
// Stall: while a result waits, bytes that yield no result keep flowing; a
// byte that would yield one holds in the input register until the slot frees.
// Reset: drops any search, empties both registers, sets magic_value and
// end_type to zero and guid_type to 97. Write cfg_* only while idle.
`include "trailer_tlv_guid_extract_top_macros.svh"

module trailer_tlv_guid_extract_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic [23:0]                     stream_id,
    input  logic                            cfg_we,
    input  logic [ttge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttge_pkg::CFG_DATA_W-1:0] cfg_data
);

    ttge_pkg::cfg_t     cfg_reg;
    ttge_pkg::in_word_t in_word;
    ttge_pkg::in_word_t word;
    ttge_pkg::result_t  res;
    ttge_pkg::result_t  out_res;
    logic               word_valid;
    logic               word_take;
    logic               res_load;
    logic               slot_free;

    // Configuration registers: plain write, unknown indexes drop the write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_value <= '0;
            cfg_reg.end_type    <= '0;
            cfg_reg.guid_type   <= ttge_pkg::GUID_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ttge_pkg::CFG_MAGIC: cfg_reg.magic_value <= cfg_data;
                ttge_pkg::CFG_END:   cfg_reg.end_type    <= cfg_data[7:0];
                ttge_pkg::CFG_GUID:  cfg_reg.guid_type   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_word.data_byte  = data_byte;
    assign in_word.first_byte = first_byte;
    assign in_word.last_byte  = last_byte;

    // Hold the accepted byte in a register ahead of the parser until the parser takes it.
    ttge_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .word_take  (word_take),
        .word_valid (word_valid),
        .word       (word)
    );

    // Advance the search state and decide the packet's result.
    ttge_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .word_valid (word_valid),
        .word       (word),
        .slot_free  (slot_free),
        .word_take  (word_take),
        .res_load   (res_load),
        .res        (res)
    );

    // Hold the result until the receiver takes it.
    ttge_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign found     = out_res.found;
    assign stream_id = out_res.stream_id;

    `TTGE_ASSERT(a_no_overwrite, !res_load || slot_free, "result loaded into a busy slot")
    `TTGE_ASSERT(a_id_zero, !(out_valid && !found) || stream_id == 24'd0, "id set when not found")
    `TTGE_ASSERT_NEXT(a_word_held, in_valid && in_ready, word_valid, "accepted byte not held")

endmodule

// File: rtl/core/ttge_in_stage.sv
// Input register stage: holds one accepted word for the parser.
module ttge_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ttge_pkg::in_word_t in_word,
    input  logic              word_take,
    output logic              word_valid,
    output ttge_pkg::in_word_t word
);

    logic               vld_reg;
    logic               vld_next;
    ttge_pkg::in_word_t word_reg;

    // Take a new word when empty or when the held one moves on this cycle.
    assign in_ready = !vld_reg || word_take;
    assign vld_next = in_ready ? in_valid : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = vld_reg;
    assign word       = word_reg;

endmodule

// File: rtl/core/ttge_parser.sv
// Trailer parser: search state and per-word update, one word per cycle unless a result waits on a busy slot.
module ttge_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  ttge_pkg::cfg_t     cfg,
    input  logic               word_valid,
    input  ttge_pkg::in_word_t word,
    input  logic               slot_free,
    output logic               word_take,
    output logic               res_load,
    output ttge_pkg::result_t  res
);

    ttge_pkg::phase_t phase_reg;
    ttge_pkg::phase_t phase_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [23:0]      magic_reg;
    logic [23:0]      magic_next;
    logic [2:0]       skip_reg;
    logic [2:0]       skip_next;
    logic [15:0]      guid_reg;
    logic [15:0]      guid_next;
    logic             res_hit;
    logic             clear;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        magic_next = magic_reg;
        skip_next  = skip_reg;
        guid_next  = guid_reg;
        res_hit    = 1'b0;
        res        = '0;
        clear      = 1'b0;

        // Start of a packet drops any search under way.
        if (word.first_byte)
        begin
            phase_next = ttge_pkg::PH_MAGIC;
            count_next = 2'd0;
            magic_next = '0;
            skip_next  = 3'd0;
            guid_next  = '0;
        end

        case (phase_next)
            ttge_pkg::PH_MAGIC:
            begin
                if (count_next != 2'd3)
                begin
                    case (count_next)
                        2'd0:    magic_next[7:0]   = word.data_byte;
                        2'd1:    magic_next[15:8]  = word.data_byte;
                        default: magic_next[23:16] = word.data_byte;
                    endcase
                    count_next = count_next + 2'd1;
                end
                else if ({word.data_byte, magic_next} != cfg.magic_value)
                begin
                    res_hit = 1'b1;
                    clear   = 1'b1;
                end
                else
                begin
                    phase_next = ttge_pkg::PH_TL;
                    count_next = 2'd0;
                end
            end
            ttge_pkg::PH_TL:
            begin
                // End type is checked before the GUID type.
                if (word.data_byte == cfg.end_type)
                begin
                    res_hit = 1'b1;
                    clear   = 1'b1;
                end
                else if (word.data_byte == cfg.guid_type)
                begin
                    phase_next = ttge_pkg::PH_GUID;
                    count_next = 2'd0;
                    guid_next  = '0;
                end
                else
                begin
                    skip_next  = 3'(word.data_byte >> ttge_pkg::LEN_SHIFT);
                    phase_next = (skip_next != 3'd0) ? ttge_pkg::PH_SKIP : ttge_pkg::PH_TL;
                end
            end
            ttge_pkg::PH_SKIP:
            begin
                skip_next = skip_next - 3'd1;
                if (skip_next == 3'd0)
                begin
                    phase_next = ttge_pkg::PH_TL;
                end
            end
            ttge_pkg::PH_GUID:
            begin
                if (count_next < 2'(ttge_pkg::GUID_BYTES - 1))
                begin
                    if (count_next == 2'd0)
                    begin
                        guid_next[7:0] = word.data_byte;
                    end
                    else
                    begin
                        guid_next[15:8] = word.data_byte;
                    end
                    count_next = count_next + 2'd1;
                end
                else
                begin
                    res_hit       = 1'b1;
                    res.found     = 1'b1;
                    res.stream_id = {word.data_byte, guid_next};
                    clear         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Packet start reached with no answer yet: report not found.
        if (!res_hit && word.last_byte && phase_next != ttge_pkg::PH_IDLE)
        begin
            res_hit = 1'b1;
            clear   = 1'b1;
        end

        if (clear)
        begin
            phase_next = ttge_pkg::PH_IDLE;
            count_next = 2'd0;
            magic_next = '0;
            skip_next  = 3'd0;
            guid_next  = '0;
        end
    end

    // Stall only when this word yields a result and the result slot is busy.
    assign word_take = word_valid && (slot_free || !res_hit);
    assign res_load  = word_take && res_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ttge_pkg::PH_IDLE;
            count_reg <= 2'd0;
            magic_reg <= '0;
            skip_reg  <= 3'd0;
            guid_reg  <= '0;
        end
        else if (word_take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            magic_reg <= magic_next;
            skip_reg  <= skip_next;
            guid_reg  <= guid_next;
        end
    end

endmodule

// File: rtl/core/ttge_out_stage.sv
// Result register stage: holds one result until the receiver takes it.
module ttge_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  ttge_pkg::result_t res,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output ttge_pkg::result_t out_res
);

    logic              vld_reg;
    logic              vld_next;
    ttge_pkg::result_t res_reg;

    assign slot_free = !vld_reg || out_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (res_load)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

// File: tb/ttge_guid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the trailer TLV GUID extractor: byte-walk predictor and result compare.
module ttge_guid_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [7:0]                      data_byte,
    input  logic                            first_byte,
    input  logic                            last_byte,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            found,
    input  logic [23:0]                     stream_id,
    input  logic                            cfg_we,
    input  logic [ttge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ttge_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              results_owed,
    output int                              results_seen,
    output int                              guids_seen
);

    ttge_pkg::cfg_t    regs;
    ttge_pkg::phase_t  walk_phase;
    logic [1:0]        walk_count;
    logic [23:0]       magic_sr;
    logic [2:0]        skip_left;
    logic [15:0]       guid_sr;
    ttge_pkg::result_t owed_q[$];

    task automatic clear_search();
        walk_phase = ttge_pkg::PH_IDLE;
        walk_count = '0;
        magic_sr   = '0;
        skip_left  = '0;
        guid_sr    = '0;
    endtask

    task automatic close_packet(input logic hit, input logic [23:0] id);
        ttge_pkg::result_t r;
        r.found     = hit;
        r.stream_id = hit ? id : 24'd0;
        owed_q.push_back(r);
        clear_search();
    endtask

    // Advance the trailer walk by one byte; queue the packet's verdict when it settles.
    task automatic walk_trailer_byte(input ttge_pkg::in_word_t w);
        logic        closed;
        logic [31:0] sig;
        closed = 1'b0;
        if (w.first_byte)
        begin
            clear_search();
            walk_phase = ttge_pkg::PH_MAGIC;
        end
        case (walk_phase)
            ttge_pkg::PH_MAGIC:
            begin
                if (walk_count < 2'd3)
                begin
                    magic_sr[walk_count*ttge_pkg::BYTE_BITS +: 8] = w.data_byte;
                    walk_count = walk_count + 2'd1;
                end
                else
                begin
                    sig = {w.data_byte, magic_sr};
                    if (sig != regs.magic_value)
                    begin
                        close_packet(1'b0, 24'd0);
                        closed = 1'b1;
                    end
                    else
                    begin
                        walk_phase = ttge_pkg::PH_TL;
                        walk_count = '0;
                    end
                end
            end
            ttge_pkg::PH_TL:
            begin
                if (w.data_byte == regs.end_type)
                begin
                    close_packet(1'b0, 24'd0);
                    closed = 1'b1;
                end
                else if (w.data_byte == regs.guid_type)
                begin
                    walk_phase = ttge_pkg::PH_GUID;
                    walk_count = '0;
                    guid_sr    = '0;
                end
                else
                begin
                    skip_left  = w.data_byte[7:5];
                    walk_phase = (skip_left != 3'd0) ? ttge_pkg::PH_SKIP : ttge_pkg::PH_TL;
                end
            end
            ttge_pkg::PH_SKIP:
            begin
                skip_left = skip_left - 3'd1;
                if (skip_left == 3'd0)
                    walk_phase = ttge_pkg::PH_TL;
            end
            ttge_pkg::PH_GUID:
            begin
                if (walk_count < 2'd2)
                begin
                    guid_sr[walk_count*ttge_pkg::BYTE_BITS +: 8] = w.data_byte;
                    walk_count = walk_count + 2'd1;
                end
                else
                begin
                    close_packet(1'b1, {w.data_byte, guid_sr});
                    closed = 1'b1;
                end
            end
            default: ;
        endcase
        if (!closed && w.last_byte && walk_phase != ttge_pkg::PH_IDLE)
            close_packet(1'b0, 24'd0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ttge_pkg::in_word_t w;
        ttge_pkg::result_t  want;
        if (!rst_n)
        begin
            regs.magic_value = '0;
            regs.end_type    = '0;
            regs.guid_type   = ttge_pkg::GUID_TYPE_RESET;
            clear_search();
            owed_q.delete();
            fail_count   = 0;
            results_owed = 0;
            results_seen = 0;
            guids_seen   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ttge_pkg::CFG_MAGIC: regs.magic_value = cfg_data;
                    ttge_pkg::CFG_END:   regs.end_type    = cfg_data[7:0];
                    ttge_pkg::CFG_GUID:  regs.guid_type   = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                w.data_byte  = data_byte;
                w.first_byte = first_byte;
                w.last_byte  = last_byte;
                walk_trailer_byte(w);
            end
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    $error("unexpected result: found=%0d stream_id=%06h", found, stream_id);
                    fail_count++;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, found);
                        fail_count++;
                    end
                    if (stream_id !== want.stream_id)
                    begin
                        $error("stream_id: expected %06h, actual %06h",
                               want.stream_id, stream_id);
                        fail_count++;
                    end
                    results_seen++;
                    if (want.found)
                        guids_seen++;
                end
            end
            results_owed = owed_q.size();
        end
    end

endmodule

// File: tb/trailer_tlv_guid_extract_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the trailer TLV GUID extractor: packet stimulus, flow control and verdict.
module trailer_tlv_guid_extract_top_tb;

    localparam int RUN_LIMIT        = 500000;
    localparam int SETTINGS_COUNT   = 7;
    localparam int BYTES_PER_SETTING = 250;
    localparam int MAX_GAP          = 12;
    localparam int LONG_STALL       = 300;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    logic [7:0]                      data_byte   = 8'd0;
    logic                            first_byte  = 1'b0;
    logic                            last_byte   = 1'b0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    logic                            found;
    logic [23:0]                     stream_id;
    logic                            cfg_we      = 1'b0;
    logic [ttge_pkg::CFG_IDX_W-1:0]  cfg_index   = ttge_pkg::CFG_MAGIC;
    logic [ttge_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    int fail_count;
    int results_owed;
    int results_seen;
    int guids_seen;

    int             cycle_count = 0;
    int             tx_bytes    = 0;
    int             n_packets   = 0;
    bit             tx_burst    = 1'b0;
    bit             rx_burst    = 1'b0;
    bit             rx_stall    = 1'b0;
    int             rx_hold;
    ttge_pkg::cfg_t cur;
    logic [7:0]     pkt_q[$];

    trailer_tlv_guid_extract_top u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .stream_id   (stream_id),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    ttge_guid_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .first_byte   (first_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .stream_id    (stream_id),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .results_seen (results_seen),
        .guids_seen   (guids_seen)
    );

    always #2 clk = ~clk;

    // Bound the run: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: after each taken word, hold off a random number of cycles.
    // Burst mode drops the hold so results drain back to back for a while.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold  <= 0;
            rx_burst <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            rx_hold <= rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0)
                rx_burst <= !rx_burst;
        end
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
        end
    end

    always @(negedge clk)
        out_ready <= rst_n && (rx_hold == 0) && !rx_stall;

    // Long back-pressure: block the output for a stretch mid-run while the
    // sender keeps offering bytes, so the result slot fills and in_ready drops.
    initial
    begin
        wait (tx_bytes >= 600);
        @(posedge clk);
        rx_stall = 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        rx_stall = 1'b0;
    end

    // Bytes 0x00/0xFF a quarter of the time, else anything.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one word after a random gap; hold it until the block takes it.
    task automatic send_word(input logic [7:0] b, input logic f, input logic l);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= f;
        last_byte  <= l;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Feed pkt_q in order; mark the tail with last_byte unless the packet is cut off.
    task automatic send_packet(input bit closed);
        for (int i = 0; i < pkt_q.size(); i++)
            send_word(pkt_q[i], i == 0, closed && (i == pkt_q.size() - 1));
        tx_bytes  += pkt_q.size();
        n_packets += 1;
    endtask

    // Build one packet in feed order: signature (low byte first), a few skip
    // TLVs, then a GUID TLV, an end TLV, one random byte or nothing, and some trailing bytes.
    // Now and then flip a signature bit or chop the packet short.
    task automatic build_packet();
        logic [31:0] sig;
        logic [7:0]  tl;
        int          tail;
        int          len;
        pkt_q.delete();
        sig = cur.magic_value;
        if ($urandom_range(0, 7) == 0)
            sig = sig ^ (32'd1 << $urandom_range(0, 31));
        for (int k = 0; k < 4; k++)
            pkt_q.push_back(sig[k*8 +: 8]);
        repeat ($urandom_range(0, 4))
        begin
            tl = 8'($urandom_range(0, 255));
            while (tl == cur.end_type || tl == cur.guid_type)
                tl = 8'($urandom_range(0, 255));
            pkt_q.push_back(tl);
            repeat (tl[7:5]) pkt_q.push_back(pick_byte());
        end
        tail = $urandom_range(0, 9);
        if (tail <= 5)
        begin
            pkt_q.push_back(cur.guid_type);
            repeat (3) pkt_q.push_back(pick_byte());
        end
        else if (tail <= 7)
        begin
            pkt_q.push_back(cur.end_type);
        end
        else if (tail == 9)
        begin
            pkt_q.push_back(pick_byte());
        end
        repeat ($urandom_range(0, 3)) pkt_q.push_back(pick_byte());
        if ($urandom_range(0, 5) == 0)
        begin
            len = $urandom_range(1, pkt_q.size());
            while (pkt_q.size() > len)
                void'(pkt_q.pop_back());
        end
    endtask

    // Drop valid and wait until every owed result is out, plus the pipe depth.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (results_owed == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input ttge_pkg::cfg_idx_t idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
    endtask

    task automatic apply_setting(input logic [31:0] m, input logic [7:0] e,
                                 input logic [7:0] g);
        write_reg(ttge_pkg::CFG_MAGIC, m);
        write_reg(ttge_pkg::CFG_END, {24'd0, e});
        write_reg(ttge_pkg::CFG_GUID, {24'd0, g});
        @(negedge clk);
        cfg_we <= 1'b0;
        cur.magic_value = m;
        cur.end_type    = e;
        cur.guid_type   = g;
    endtask

    initial
    begin : stimulus
        int       setting_start;
        logic [7:0] same_type;

        cur.magic_value = '0;
        cur.end_type    = '0;
        cur.guid_type   = ttge_pkg::GUID_TYPE_RESET;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed packets under the reset settings (signature 0, end 0, GUID type 97).
        pkt_q = '{8'h5A};
        send_packet(1'b1);                  // single-byte packet
        send_word(8'hFF, 1'b0, 1'b1);       // stray byte while idle
        pkt_q = '{8'h00, 8'h00};
        send_packet(1'b0);                  // cut off mid-signature by the next packet
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'hAA, 8'h61, 8'hFF, 8'hFF, 8'hFF};
        send_packet(1'b1);                  // skip one, then GUID ending on the packet start
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h80};
        send_packet(1'b1);                  // bad signature on its top byte
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(1'b1);                  // end TLV right after the signature

        for (int s = 0; s < SETTINGS_COUNT; s++)
        begin
            if (s > 0)
            begin
                drain();
                case (s)
                    1: apply_setting(32'hFFFF_FFFF, 8'hFF, 8'h00);
                    2: apply_setting(32'h0000_0000, 8'h00, 8'hFF);
                    3:
                    begin
                        // End and GUID types equal: end must win.
                        same_type = 8'($urandom_range(0, 255));
                        apply_setting($urandom, same_type, same_type);
                    end
                    default: apply_setting($urandom, 8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)));
                endcase
            end
            setting_start = tx_bytes;
            while (tx_bytes - setting_start < BYTES_PER_SETTING)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(pick_byte(), 1'b0, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 11) == 0)
                begin
                    build_packet();
                    send_packet(1'b0);
                end
                build_packet();
                send_packet(1'b1);
                if ($urandom_range(0, 5) == 0)
                    tx_burst = !tx_burst;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d packets (%0d bytes) over %0d register settings, incl. extreme",
                 n_packets, tx_bytes, SETTINGS_COUNT);
        $display("and equal end/GUID types; %0d results checked, %0d with a stream id.",
                 results_seen, guids_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ttge_pkg.sv
rtl/core/ttge_in_stage.sv
rtl/core/ttge_parser.sv
rtl/core/ttge_out_stage.sv
rtl/core/trailer_tlv_guid_extract_top.sv
tb/ttge_guid_checker.sv
tb/trailer_tlv_guid_extract_top_tb.sv
